/* rtl/core/receive_window_rate_meter_top_macros.svh */
// Assertion macros shared by the checker of the receive window rate meter.
`ifndef RECEIVE_WINDOW_RATE_METER_TOP_MACROS_SVH
`define RECEIVE_WINDOW_RATE_METER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RWRM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RWRM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/rwrm_pkg.sv */
// Shared constants, types and helper functions of the receive window rate meter.
`default_nettype none

package rwrm_pkg;

    localparam int WINDOW_ENTRIES = 8;
    localparam int PTR_W          = $clog2(WINDOW_ENTRIES);
    localparam int FILL_W         = $clog2(WINDOW_ENTRIES + 1);
    localparam int TRACK_SLOTS    = 8;
    localparam int NSLOT          = TRACK_SLOTS + 1;
    localparam int SLOT_W         = 4;
    localparam int DATA_W         = 32;
    localparam int MASK_W         = 64;
    localparam int ID_W           = 6;
    localparam int CNT_W          = $clog2(DATA_W + 1);

    // Snapshot word: time, total bytes, total frames, slot bytes, slot frames.
    localparam int SNAP_WORDS = 3 + 2 * NSLOT;
    localparam int SNAP_W     = SNAP_WORDS * DATA_W;
    localparam int TB_BASE    = DATA_W;
    localparam int TF_BASE    = 2 * DATA_W;
    localparam int SB_BASE    = 3 * DATA_W;
    localparam int SF_BASE    = SB_BASE + NSLOT * DATA_W;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [1:0] KIND_BYTES  = 2'd0;
    localparam logic [1:0] KIND_FRAMES = 2'd1;
    localparam logic [1:0] KIND_AVG    = 2'd2;

    typedef struct packed {
        logic              in_load;
        logic              frame_add;
        logic              tick_snap;
        logic              cfg_clear;
        logic              prep;
        logic              div_start;
        logic              div_store;
        logic              out_load;
        logic              out_last;
        logic              job_total;
        logic [1:0]        job_kind;
        logic [SLOT_W-1:0] job_slot;
    } rwrm_cmd_t;

    typedef struct packed {
        logic              full;
        logic              div_done;
        logic              out_free;
        logic [SLOT_W-1:0] n_active;
    } rwrm_status_t;

    // Slot of a track id: rank of the id among the set mask bits above bit 0.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [MASK_W-1:0] mask,
                                                  input logic [ID_W-1:0]   id);
        logic [ID_W:0] rank;
        rank = '0;
        for (int i = 1; i < MASK_W; i++) begin
            if ((i <= int'(id)) && mask[i]) begin
                rank = rank + 1'b1;
            end
        end
        if ((id == '0) || !mask[id] || (rank > (ID_W+1)'(TRACK_SLOTS))) begin
            return '0;
        end
        return rank[SLOT_W-1:0];
    endfunction

    // Number of slots beside the catch-all slot, capped at the slot count.
    function automatic logic [SLOT_W-1:0] active_count(input logic [MASK_W-1:0] mask);
        logic [ID_W:0] n;
        n = '0;
        for (int i = 1; i < MASK_W; i++) begin
            if (mask[i]) begin
                n = n + 1'b1;
            end
        end
        if (n > (ID_W+1)'(TRACK_SLOTS)) begin
            return SLOT_W'(TRACK_SLOTS);
        end
        return n[SLOT_W-1:0];
    endfunction

    // Times 1000 modulo 2^32 as 1024 - 32 + 8.
    function automatic logic [DATA_W-1:0] times_ms(input logic [DATA_W-1:0] x);
        return (x << 10) - (x << 5) + (x << 3);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/rwrm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rwrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/rwrm_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle; divide by zero gives zero.
`default_nettype none

module rwrm_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [rwrm_pkg::DATA_W-1:0] dividend,
    input  wire logic [rwrm_pkg::DATA_W-1:0] divisor,
    output logic                             done,
    output logic      [rwrm_pkg::DATA_W-1:0] quotient
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [rwrm_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [rwrm_pkg::DATA_W-1:0]      quo_reg, quo_next;
    logic [rwrm_pkg::DATA_W-1:0]      dvs_reg, dvs_next;
    logic [rwrm_pkg::DATA_W:0]        rem_reg, rem_next;
    logic [rwrm_pkg::DATA_W:0]        rem_sh;
    logic                             ge;

    always_comb begin
        rem_sh    = {rem_reg[rwrm_pkg::DATA_W-1:0], quo_reg[rwrm_pkg::DATA_W-1]};
        ge        = rem_sh >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start) begin
            dvs_next  = divisor;
            rem_next  = '0;
            cnt_next  = rwrm_pkg::CNT_W'(rwrm_pkg::DATA_W);
            busy_next = divisor != '0;
            done_next = divisor == '0;
            quo_next  = (divisor == '0) ? '0 : dividend;
        end else if (busy_reg) begin
            rem_next = ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            quo_next = {quo_reg[rwrm_pkg::DATA_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == rwrm_pkg::CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* rtl/core/rwrm_ctrl.sv */
// Controller state machine: request handshakes and the tick job sequence.
`default_nettype none

module rwrm_ctrl (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    input  wire logic                     s_op,
    output logic                          s_ready,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire rwrm_pkg::rwrm_status_t   st,
    output rwrm_pkg::rwrm_cmd_t           cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_FRAME  = 4'd1;
    localparam logic [3:0] ST_TICK   = 4'd2;
    localparam logic [3:0] ST_LOAD   = 4'd3;
    localparam logic [3:0] ST_PREP   = 4'd4;
    localparam logic [3:0] ST_DSTART = 4'd5;
    localparam logic [3:0] ST_DWAIT  = 4'd6;
    localparam logic [3:0] ST_DSTORE = 4'd7;
    localparam logic [3:0] ST_EMIT   = 4'd8;

    logic [3:0]                  state_reg, state_next;
    logic                        total_reg, total_next;
    logic [1:0]                  kind_reg, kind_next;
    logic [rwrm_pkg::SLOT_W-1:0] slot_reg, slot_next;

    always_comb begin
        state_next = state_reg;
        total_next = total_reg;
        kind_next  = kind_reg;
        slot_next  = slot_reg;
        cmd        = '0;
        cmd.job_total = total_reg;
        cmd.job_kind  = kind_reg;
        cmd.job_slot  = slot_reg;
        s_ready    = 1'b0;
        cfg_ready  = state_reg == ST_IDLE;
        case (state_reg)
            ST_IDLE: begin
                s_ready       = !cfg_valid;
                cmd.cfg_clear = cfg_valid;
                if (s_valid && !cfg_valid) begin
                    cmd.in_load = 1'b1;
                    state_next  = (s_op == rwrm_pkg::OP_TICK) ? ST_TICK : ST_FRAME;
                end
            end
            ST_FRAME: begin
                cmd.frame_add = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_TICK: begin
                cmd.tick_snap = 1'b1;
                total_next    = 1'b1;
                kind_next     = rwrm_pkg::KIND_BYTES;
                slot_next     = '0;
                state_next    = ST_LOAD;
            end
            ST_LOAD: begin
                state_next = st.full ? ST_PREP : ST_EMIT;
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_DSTART;
            end
            ST_DSTART: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (st.div_done) begin
                    state_next = ST_DSTORE;
                end
            end
            ST_DSTORE: begin
                cmd.div_store = 1'b1;
                if (total_reg) begin
                    if (kind_reg == rwrm_pkg::KIND_BYTES) begin
                        kind_next  = rwrm_pkg::KIND_FRAMES;
                        state_next = ST_DSTART;
                    end else begin
                        total_next = 1'b0;
                        kind_next  = rwrm_pkg::KIND_BYTES;
                        slot_next  = '0;
                        state_next = ST_PREP;
                    end
                end else if (kind_reg != rwrm_pkg::KIND_AVG) begin
                    kind_next  = kind_reg + 1'b1;
                    state_next = ST_DSTART;
                end else if (slot_reg == rwrm_pkg::SLOT_W'(rwrm_pkg::NSLOT - 1)) begin
                    slot_next  = '0;
                    state_next = ST_EMIT;
                end else begin
                    slot_next  = slot_reg + 1'b1;
                    kind_next  = rwrm_pkg::KIND_BYTES;
                    state_next = ST_PREP;
                end
            end
            ST_EMIT: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = slot_reg == st.n_active;
                    if (slot_reg == st.n_active) begin
                        state_next = ST_IDLE;
                    end else begin
                        slot_next = slot_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            total_reg <= 1'b0;
            kind_reg  <= rwrm_pkg::KIND_BYTES;
            slot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            total_reg <= total_next;
            kind_reg  <= kind_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/rwrm_datapath.sv */
// Datapath: live counters, snapshot ring, divider operands, held rates and output register.
`default_nettype none

module rwrm_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rwrm_pkg::rwrm_cmd_t           cmd,
    output rwrm_pkg::rwrm_status_t             st,
    input  wire logic                          s_op,
    input  wire logic [rwrm_pkg::ID_W-1:0]     s_track_id,
    input  wire logic [rwrm_pkg::DATA_W-1:0]   s_frame_length,
    input  wire logic [rwrm_pkg::DATA_W-1:0]   s_now_ms,
    input  wire logic [rwrm_pkg::MASK_W-1:0]   cfg_data,
    input  wire logic                          m_ready,
    output logic                               m_valid,
    output logic      [rwrm_pkg::SLOT_W-1:0]   m_slot_index,
    output logic                               m_window_full,
    output logic      [rwrm_pkg::DATA_W-1:0]   m_slot_bytes_rate,
    output logic      [rwrm_pkg::DATA_W-1:0]   m_slot_frames_rate,
    output logic      [rwrm_pkg::DATA_W-1:0]   m_slot_avg_frame_size,
    output logic      [rwrm_pkg::DATA_W-1:0]   m_total_bytes_rate,
    output logic      [rwrm_pkg::DATA_W-1:0]   m_total_frames_rate,
    output logic      [rwrm_pkg::DATA_W-1:0]   m_peak_bytes_rate,
    output logic      [rwrm_pkg::DATA_W-1:0]   m_peak_frames_rate,
    output logic                               m_last
);

    localparam int DW = rwrm_pkg::DATA_W;
    localparam int NS = rwrm_pkg::NSLOT;

    // Mask register and derived slot count.
    logic [rwrm_pkg::MASK_W-1:0] mask_reg;
    logic [rwrm_pkg::SLOT_W-1:0] n_active_reg;

    // Input register.
    logic [rwrm_pkg::ID_W-1:0]   id_reg;
    logic [DW-1:0]               len_reg;
    logic [DW-1:0]               now_reg;

    // Live totals (low 32 bits are all the rate math uses).
    logic [DW-1:0] live_tb_reg, live_tf_reg;
    logic [DW-1:0] live_sb_reg [NS];
    logic [DW-1:0] live_sf_reg [NS];
    logic [rwrm_pkg::SLOT_W-1:0] frame_slot;

    // Ring bookkeeping.
    logic [rwrm_pkg::PTR_W-1:0]  newest_reg, oldest_reg;
    logic [rwrm_pkg::FILL_W-1:0] fill_reg;
    logic                        full_reg;
    logic                        full_now;

    // Snapshot memory.
    logic [rwrm_pkg::SNAP_W-1:0] snap_wdata, snap_rdata;

    // Operands.
    logic [DW-1:0] d_reg, sb_reg, sf_reg;
    logic [DW-1:0] d_calc, db_calc, df_calc;
    logic [DW-1:0] div_dividend, div_divisor, div_q;
    logic          div_done;
    logic [DW:0]   peak_sum;

    // Held rates.
    logic [DW-1:0] held_tb_reg, held_tf_reg, peak_b_reg, peak_f_reg;
    logic [DW-1:0] held_sb_reg [NS];
    logic [DW-1:0] held_sf_reg [NS];
    logic [DW-1:0] held_avg_reg [NS];

    logic m_valid_reg;

    assign frame_slot = rwrm_pkg::slot_of(mask_reg, id_reg);
    assign full_now   = fill_reg >= rwrm_pkg::FILL_W'(rwrm_pkg::WINDOW_ENTRIES - 1);

    always_comb begin
        snap_wdata = '0;
        snap_wdata[DW-1:0]                        = now_reg;
        snap_wdata[rwrm_pkg::TB_BASE +: DW]       = live_tb_reg;
        snap_wdata[rwrm_pkg::TF_BASE +: DW]       = live_tf_reg;
        for (int i = 0; i < NS; i++) begin
            snap_wdata[rwrm_pkg::SB_BASE + DW * i +: DW] = live_sb_reg[i];
            snap_wdata[rwrm_pkg::SF_BASE + DW * i +: DW] = live_sf_reg[i];
        end
    end

    rwrm_ram #(
        .WIDTH (rwrm_pkg::SNAP_W),
        .DEPTH (rwrm_pkg::WINDOW_ENTRIES)
    ) u_ring (
        .aclk  (aclk),
        .we    (cmd.tick_snap),
        .waddr (newest_reg),
        .wdata (snap_wdata),
        .re    (cmd.tick_snap),
        .raddr (oldest_reg),
        .rdata (snap_rdata)
    );

    // Deltas against the oldest snapshot for the job at hand.
    always_comb begin
        d_calc = now_reg - snap_rdata[DW-1:0];
        if (cmd.job_total) begin
            db_calc = live_tb_reg - snap_rdata[rwrm_pkg::TB_BASE +: DW];
            df_calc = live_tf_reg - snap_rdata[rwrm_pkg::TF_BASE +: DW];
        end else begin
            db_calc = live_sb_reg[cmd.job_slot]
                    - snap_rdata[rwrm_pkg::SB_BASE + DW * int'(cmd.job_slot) +: DW];
            df_calc = live_sf_reg[cmd.job_slot]
                    - snap_rdata[rwrm_pkg::SF_BASE + DW * int'(cmd.job_slot) +: DW];
        end
    end

    always_comb begin
        case (cmd.job_kind)
            rwrm_pkg::KIND_BYTES: begin
                div_dividend = sb_reg + (d_reg >> 1);
                div_divisor  = d_reg;
            end
            rwrm_pkg::KIND_FRAMES: begin
                div_dividend = sf_reg + (d_reg >> 1);
                div_divisor  = d_reg;
            end
            default: begin
                div_dividend = sb_reg + (sf_reg >> 1);
                div_divisor  = sf_reg;
            end
        endcase
    end

    rwrm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign peak_sum = (cmd.job_kind == rwrm_pkg::KIND_BYTES)
                    ? ({1'b0, peak_b_reg} + {1'b0, div_q})
                    : ({1'b0, peak_f_reg} + {1'b0, div_q});

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            id_reg  <= s_track_id;
            len_reg <= s_frame_length;
            if (s_op == rwrm_pkg::OP_TICK) begin
                now_reg <= s_now_ms;
            end
        end
        if (cmd.prep) begin
            d_reg  <= d_calc;
            sb_reg <= rwrm_pkg::times_ms(db_calc);
            sf_reg <= rwrm_pkg::times_ms(df_calc);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.cfg_clear) begin
            mask_reg     <= aresetn ? cfg_data : '0;
            n_active_reg <= aresetn ? rwrm_pkg::active_count(cfg_data) : '0;
            live_tb_reg  <= '0;
            live_tf_reg  <= '0;
            newest_reg   <= '0;
            oldest_reg   <= '0;
            fill_reg     <= '0;
            full_reg     <= 1'b0;
            held_tb_reg  <= '0;
            held_tf_reg  <= '0;
            peak_b_reg   <= '0;
            peak_f_reg   <= '0;
            for (int i = 0; i < NS; i++) begin
                live_sb_reg[i]  <= '0;
                live_sf_reg[i]  <= '0;
                held_sb_reg[i]  <= '0;
                held_sf_reg[i]  <= '0;
                held_avg_reg[i] <= '0;
            end
        end else begin
            if (cmd.frame_add) begin
                live_tb_reg             <= live_tb_reg + len_reg;
                live_tf_reg             <= live_tf_reg + 1'b1;
                live_sb_reg[frame_slot] <= live_sb_reg[frame_slot] + len_reg;
                live_sf_reg[frame_slot] <= live_sf_reg[frame_slot] + 1'b1;
            end
            if (cmd.tick_snap) begin
                full_reg   <= full_now;
                newest_reg <= (newest_reg == rwrm_pkg::PTR_W'(rwrm_pkg::WINDOW_ENTRIES - 1))
                            ? '0 : newest_reg + 1'b1;
                if (full_now) begin
                    fill_reg   <= rwrm_pkg::FILL_W'(rwrm_pkg::WINDOW_ENTRIES);
                    oldest_reg <= (oldest_reg ==
                                   rwrm_pkg::PTR_W'(rwrm_pkg::WINDOW_ENTRIES - 1))
                                ? '0 : oldest_reg + 1'b1;
                end else begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (cmd.div_store) begin
                if (cmd.job_total) begin
                    if (cmd.job_kind == rwrm_pkg::KIND_BYTES) begin
                        held_tb_reg <= div_q;
                        if ((d_reg != '0) && (peak_b_reg < div_q)) begin
                            peak_b_reg <= peak_sum[DW:1];
                        end
                    end else begin
                        held_tf_reg <= div_q;
                        if ((d_reg != '0) && (peak_f_reg < div_q)) begin
                            peak_f_reg <= peak_sum[DW:1];
                        end
                    end
                end else begin
                    case (cmd.job_kind)
                        rwrm_pkg::KIND_BYTES:  held_sb_reg[cmd.job_slot]  <= div_q;
                        rwrm_pkg::KIND_FRAMES: held_sf_reg[cmd.job_slot]  <= div_q;
                        default:               held_avg_reg[cmd.job_slot] <= div_q;
                    endcase
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_slot_index          <= cmd.job_slot;
            m_window_full         <= full_reg;
            m_slot_bytes_rate     <= held_sb_reg[cmd.job_slot];
            m_slot_frames_rate    <= held_sf_reg[cmd.job_slot];
            m_slot_avg_frame_size <= held_avg_reg[cmd.job_slot];
            m_total_bytes_rate    <= held_tb_reg;
            m_total_frames_rate   <= held_tf_reg;
            m_peak_bytes_rate     <= peak_b_reg;
            m_peak_frames_rate    <= peak_f_reg;
            m_last                <= cmd.out_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign st.full     = full_reg;
    assign st.div_done = div_done;
    assign st.out_free = !m_valid_reg || m_ready;
    assign st.n_active = n_active_reg;

endmodule

`default_nettype wire

/* rtl/core/receive_window_rate_meter_top.sv */
// Top level of the receive window rate meter: controller, datapath and ports.
//
// Channel   Direction  Handshake              Moves
// s_*       in         s_valid / s_ready      one request: frame event or tick
// m_*       out        m_valid / m_ready      one result item per reported slot
// cfg_*     in         cfg_valid / cfg_ready  a write of the 64-bit track mask
//
// A frame request is registered first, then comes the read-modify-write of the live
// totals and its slot counter (the slot comes from the mask rank of the id).
// Before the window fills, a tick saves a snapshot and emits one item per reported slot.
// Once full, a tick runs 29 divisions on one shared divider, each a start, a wait
// for the divider and a store, after an operand setup for the totals and one per slot;
// the slot items follow.
// Reset and a mask write both clear all counters, pointers and held rates; the
// snapshot ring needs no clearing since only written entries are ever read.
// The last result waits in the output register while the next request is taken.
`default_nettype none

module receive_window_rate_meter_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_op,
    input  wire logic [rwrm_pkg::ID_W-1:0]     s_track_id,
    input  wire logic [rwrm_pkg::DATA_W-1:0]   s_frame_length,
    input  wire logic [rwrm_pkg::DATA_W-1:0]   s_now_ms,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [rwrm_pkg::SLOT_W-1:0]   m_slot_index,
    output logic                               m_window_full,
    output logic      [rwrm_pkg::DATA_W-1:0]   m_slot_bytes_rate,
    output logic      [rwrm_pkg::DATA_W-1:0]   m_slot_frames_rate,
    output logic      [rwrm_pkg::DATA_W-1:0]   m_slot_avg_frame_size,
    output logic      [rwrm_pkg::DATA_W-1:0]   m_total_bytes_rate,
    output logic      [rwrm_pkg::DATA_W-1:0]   m_total_frames_rate,
    output logic      [rwrm_pkg::DATA_W-1:0]   m_peak_bytes_rate,
    output logic      [rwrm_pkg::DATA_W-1:0]   m_peak_frames_rate,
    output logic                               m_last,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rwrm_pkg::MASK_W-1:0]   cfg_data
);

    // Commands flow from the controller to the datapath; status flows back.
    rwrm_pkg::rwrm_cmd_t    cmd;
    rwrm_pkg::rwrm_status_t st;

    // The controller owns both input handshakes and the order of the tick jobs.
    rwrm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_op      (s_op),
        .s_ready   (s_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .st        (st),
        .cmd       (cmd)
    );

    // The datapath holds every counter, the ring, the divider and the result register.
    rwrm_datapath u_datapath (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cmd                   (cmd),
        .st                    (st),
        .s_op                  (s_op),
        .s_track_id            (s_track_id),
        .s_frame_length        (s_frame_length),
        .s_now_ms              (s_now_ms),
        .cfg_data              (cfg_data),
        .m_ready               (m_ready),
        .m_valid               (m_valid),
        .m_slot_index          (m_slot_index),
        .m_window_full         (m_window_full),
        .m_slot_bytes_rate     (m_slot_bytes_rate),
        .m_slot_frames_rate    (m_slot_frames_rate),
        .m_slot_avg_frame_size (m_slot_avg_frame_size),
        .m_total_bytes_rate    (m_total_bytes_rate),
        .m_total_frames_rate   (m_total_frames_rate),
        .m_peak_bytes_rate     (m_peak_bytes_rate),
        .m_peak_frames_rate    (m_peak_frames_rate),
        .m_last                (m_last)
    );

endmodule

`default_nettype wire

/* rtl/core/rwrm_checker.sv */
// Port-level checker of the receive window rate meter and its bind.
`default_nettype none
`include "receive_window_rate_meter_top_macros.svh"

module rwrm_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic                        s_op,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [rwrm_pkg::SLOT_W-1:0] m_slot_index,
    input wire logic                        m_last,
    input wire logic                        cfg_valid,
    input wire logic                        cfg_ready
);

    // A result that is stalled keeps its slot and its last flag.
    `RWRM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_slot_index) && $stable(m_last), "stalled result changed")

    // No slot index beyond the catch-all slot plus the TRACK_SLOTS track slots is reported.
    `RWRM_ASSERT_NOW(a_slot_range, aclk, aresetn, m_valid, m_slot_index <= rwrm_pkg::SLOT_W'(rwrm_pkg::TRACK_SLOTS), "slot index out of range")

    // Requests are only taken while a mask write could be taken too.
    `RWRM_ASSERT_NOW(a_ready_idle, aclk, aresetn, s_ready, cfg_ready && !cfg_valid, "request taken outside idle")

    // A frame event occupies the block for its update cycle.
    `RWRM_ASSERT_NEXT(a_frame_busy, aclk, aresetn, s_valid && s_ready && !s_op, !s_ready && !cfg_ready, "frame update overlapped")

endmodule

bind receive_window_rate_meter_top rwrm_checker u_checker (.*);

`default_nettype wire

/* test/tb_receive_window_rate_meter_top.sv */
// Self-checking testbench of the receive window rate meter top level.
`timescale 1ns / 1ps

module tb_receive_window_rate_meter_top;

    // One slot item of a tick report, as the block drives it.
    typedef struct {
        logic [rwrm_pkg::SLOT_W-1:0] slot_index;
        logic                        window_full;
        logic [rwrm_pkg::DATA_W-1:0] slot_bytes_rate;
        logic [rwrm_pkg::DATA_W-1:0] slot_frames_rate;
        logic [rwrm_pkg::DATA_W-1:0] slot_avg_frame_size;
        logic [rwrm_pkg::DATA_W-1:0] total_bytes_rate;
        logic [rwrm_pkg::DATA_W-1:0] total_frames_rate;
        logic [rwrm_pkg::DATA_W-1:0] peak_bytes_rate;
        logic [rwrm_pkg::DATA_W-1:0] peak_frames_rate;
        logic                        last;
    } slot_report_t;

    // Rate meter model plus the queue of slot reports it still expects.
    class rate_meter_scoreboard;
        logic [rwrm_pkg::MASK_W-1:0] mask;
        logic [31:0] snap_time [rwrm_pkg::WINDOW_ENTRIES];
        logic [63:0] snap_bytes [rwrm_pkg::WINDOW_ENTRIES];
        logic [63:0] snap_frames [rwrm_pkg::WINDOW_ENTRIES];
        logic [63:0] snap_slot_bytes [rwrm_pkg::WINDOW_ENTRIES][rwrm_pkg::NSLOT];
        logic [63:0] snap_slot_frames [rwrm_pkg::WINDOW_ENTRIES][rwrm_pkg::NSLOT];
        int unsigned newest, oldest, filled;
        logic [31:0] rate_bytes, rate_frames, peak_bytes, peak_frames;
        logic [31:0] slot_rate_bytes [rwrm_pkg::NSLOT];
        logic [31:0] slot_rate_frames [rwrm_pkg::NSLOT];
        logic [31:0] slot_avg [rwrm_pkg::NSLOT];
        slot_report_t pending_reports [$];
        int errors;

        function void clear_counters();
            for (int e = 0; e < rwrm_pkg::WINDOW_ENTRIES; e++) begin
                snap_time[e] = '0;
                snap_bytes[e] = '0;
                snap_frames[e] = '0;
                for (int s = 0; s < rwrm_pkg::NSLOT; s++) begin
                    snap_slot_bytes[e][s] = '0;
                    snap_slot_frames[e][s] = '0;
                end
            end
            for (int s = 0; s < rwrm_pkg::NSLOT; s++) begin
                slot_rate_bytes[s] = '0;
                slot_rate_frames[s] = '0;
                slot_avg[s] = '0;
            end
            newest = 0;
            oldest = 0;
            filled = 0;
            rate_bytes = '0;
            rate_frames = '0;
            peak_bytes = '0;
            peak_frames = '0;
        endfunction

        function void write_mask(logic [rwrm_pkg::MASK_W-1:0] value);
            mask = value;
            clear_counters();
        endfunction

        function int unsigned track_slot(int unsigned id);
            int unsigned rank;
            rank = 0;
            if (id == 0 || !mask[id]) return 0;
            for (int i = 1; i <= id; i++) if (mask[i]) rank++;
            return rank > rwrm_pkg::TRACK_SLOTS ? 0 : rank;
        endfunction

        function int unsigned slots_in_use();
            int unsigned n;
            n = 0;
            for (int i = 1; i < rwrm_pkg::MASK_W; i++) if (mask[i]) n++;
            return n > rwrm_pkg::TRACK_SLOTS ? rwrm_pkg::TRACK_SLOTS : n;
        endfunction

        function logic [31:0] per_second(logic [31:0] scaled, logic [31:0] span);
            logic [31:0] rounded;
            if (span == 0) return '0;
            rounded = scaled + (span >> 1);
            return rounded / span;
        endfunction

        function logic [31:0] raise_peak(logic [31:0] peak, logic [31:0] rate);
            logic [32:0] sum;
            if (peak >= rate) return peak;
            sum = {1'b0, peak} + {1'b0, rate};
            return sum[32:1];
        endfunction

        function void recompute_rates();
            logic [31:0] span, db, df, sb, sf;
            logic [63:0] delta;
            span = snap_time[newest] - snap_time[oldest];
            delta = snap_bytes[newest] - snap_bytes[oldest];
            db = delta[31:0] * 32'd1000;
            delta = snap_frames[newest] - snap_frames[oldest];
            df = delta[31:0] * 32'd1000;
            if (span == 0) begin
                rate_bytes = '0;
                rate_frames = '0;
            end else begin
                rate_bytes = per_second(db, span);
                peak_bytes = raise_peak(peak_bytes, rate_bytes);
                rate_frames = per_second(df, span);
                peak_frames = raise_peak(peak_frames, rate_frames);
            end
            for (int s = 0; s < rwrm_pkg::NSLOT; s++) begin
                delta = snap_slot_bytes[newest][s] - snap_slot_bytes[oldest][s];
                sb = delta[31:0] * 32'd1000;
                delta = snap_slot_frames[newest][s] - snap_slot_frames[oldest][s];
                sf = delta[31:0] * 32'd1000;
                slot_rate_bytes[s] = per_second(sb, span);
                slot_rate_frames[s] = per_second(sf, span);
                slot_avg[s] = (sf == 0) ? 32'd0 : (sb + (sf >> 1)) / sf;
            end
        endfunction

        // Applies one accepted request and queues the slot reports it causes.
        function void note_request(logic op, logic [rwrm_pkg::ID_W-1:0] id,
                                   logic [31:0] len, logic [31:0] now);
            int unsigned slot, n, nx;
            bit full;
            slot_report_t rep;
            if (op == rwrm_pkg::OP_FRAME) begin
                slot = track_slot(id);
                snap_time[newest] = now;
                snap_frames[newest] += 1;
                snap_bytes[newest] += len;
                snap_slot_bytes[newest][slot] += len;
                snap_slot_frames[newest][slot] += 1;
                return;
            end
            filled = (filled >= rwrm_pkg::WINDOW_ENTRIES) ? rwrm_pkg::WINDOW_ENTRIES
                                                          : filled + 1;
            full = (filled >= rwrm_pkg::WINDOW_ENTRIES);
            snap_time[newest] = now;
            if (full) recompute_rates();
            n = slots_in_use();
            for (int s = 0; s <= n; s++) begin
                rep.slot_index = rwrm_pkg::SLOT_W'(s);
                rep.window_full = full;
                rep.slot_bytes_rate = slot_rate_bytes[s];
                rep.slot_frames_rate = slot_rate_frames[s];
                rep.slot_avg_frame_size = slot_avg[s];
                rep.total_bytes_rate = rate_bytes;
                rep.total_frames_rate = rate_frames;
                rep.peak_bytes_rate = peak_bytes;
                rep.peak_frames_rate = peak_frames;
                rep.last = (s == n);
                pending_reports.push_back(rep);
            end
            nx = (newest + 1) % rwrm_pkg::WINDOW_ENTRIES;
            if (full) oldest = (oldest + 1) % rwrm_pkg::WINDOW_ENTRIES;
            snap_time[nx] = snap_time[newest];
            snap_bytes[nx] = snap_bytes[newest];
            snap_frames[nx] = snap_frames[newest];
            for (int s = 0; s < rwrm_pkg::NSLOT; s++) begin
                snap_slot_bytes[nx][s] = snap_slot_bytes[newest][s];
                snap_slot_frames[nx][s] = snap_slot_frames[newest][s];
            end
            newest = nx;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_report(slot_report_t got);
            slot_report_t want;
            if (pending_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected slot report, expected none, actual slot %0d",
                         $time, got.slot_index);
                return;
            end
            want = pending_reports.pop_front();
            compare_field("slot_index", want.slot_index, got.slot_index);
            compare_field("window_full", want.window_full, got.window_full);
            compare_field("slot_bytes_rate", want.slot_bytes_rate, got.slot_bytes_rate);
            compare_field("slot_frames_rate", want.slot_frames_rate, got.slot_frames_rate);
            compare_field("slot_avg_frame_size", want.slot_avg_frame_size,
                          got.slot_avg_frame_size);
            compare_field("total_bytes_rate", want.total_bytes_rate, got.total_bytes_rate);
            compare_field("total_frames_rate", want.total_frames_rate, got.total_frames_rate);
            compare_field("peak_bytes_rate", want.peak_bytes_rate, got.peak_bytes_rate);
            compare_field("peak_frames_rate", want.peak_frames_rate, got.peak_frames_rate);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic aclk, aresetn;
    logic s_valid, s_ready, s_op;
    logic [rwrm_pkg::ID_W-1:0] s_track_id;
    logic [rwrm_pkg::DATA_W-1:0] s_frame_length, s_now_ms;
    logic m_valid, m_ready;
    logic [rwrm_pkg::SLOT_W-1:0] m_slot_index;
    logic m_window_full, m_last;
    logic [rwrm_pkg::DATA_W-1:0] m_slot_bytes_rate, m_slot_frames_rate;
    logic [rwrm_pkg::DATA_W-1:0] m_slot_avg_frame_size;
    logic [rwrm_pkg::DATA_W-1:0] m_total_bytes_rate, m_total_frames_rate;
    logic [rwrm_pkg::DATA_W-1:0] m_peak_bytes_rate, m_peak_frames_rate;
    logic cfg_valid, cfg_ready;
    logic [rwrm_pkg::MASK_W-1:0] cfg_data;

    receive_window_rate_meter_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_track_id(s_track_id),
        .s_frame_length(s_frame_length), .s_now_ms(s_now_ms),
        .m_valid(m_valid), .m_ready(m_ready), .m_slot_index(m_slot_index),
        .m_window_full(m_window_full), .m_slot_bytes_rate(m_slot_bytes_rate),
        .m_slot_frames_rate(m_slot_frames_rate),
        .m_slot_avg_frame_size(m_slot_avg_frame_size),
        .m_total_bytes_rate(m_total_bytes_rate), .m_total_frames_rate(m_total_frames_rate),
        .m_peak_bytes_rate(m_peak_bytes_rate), .m_peak_frames_rate(m_peak_frames_rate),
        .m_last(m_last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    localparam int STALL_LIMIT = 40000;
    // Cycles allowed after the last report for a frame request still in flight.
    localparam int SETTLE_CYCLES = 50;

    rate_meter_scoreboard meter_sb;
    int sender_idle_pct;
    int receiver_idle_pct;
    int quiet_cycles;
    logic [31:0] clock_ms;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // The receiver drops ready at random; each accepted report is checked at the edge.
    initial begin
        slot_report_t got;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.slot_index = m_slot_index;
                got.window_full = m_window_full;
                got.slot_bytes_rate = m_slot_bytes_rate;
                got.slot_frames_rate = m_slot_frames_rate;
                got.slot_avg_frame_size = m_slot_avg_frame_size;
                got.total_bytes_rate = m_total_bytes_rate;
                got.total_frames_rate = m_total_frames_rate;
                got.peak_bytes_rate = m_peak_bytes_rate;
                got.peak_frames_rate = m_peak_frames_rate;
                got.last = m_last;
                meter_sb.check_report(got);
            end
        end
    end

    // The watchdog ends the run when no channel has moved anything for too long.
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
                || !aresetn) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[receive_window_rate_meter_top] ERROR");
                $finish;
            end
        end
    end

    // Sends one request. Valid only drops when the sender decides to idle.
    task automatic send_request(logic op, logic [rwrm_pkg::ID_W-1:0] id, logic [31:0] len,
                                logic [31:0] now);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_track_id <= id;
        s_frame_length <= len;
        s_now_ms <= now;
        do @(posedge aclk); while (!s_ready);
        meter_sb.note_request(op, id, len, now);
    endtask

    task automatic drain_reports();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (meter_sb.pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mask writes only happen with the block idle; each one restarts the window.
    task automatic write_track_mask(logic [rwrm_pkg::MASK_W-1:0] value);
        drain_reports();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        meter_sb.write_mask(value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(logic [rwrm_pkg::ID_W-1:0] id, logic [31:0] len);
        send_request(rwrm_pkg::OP_FRAME, id, len, clock_ms);
    endtask

    task automatic send_tick(logic [31:0] step_ms);
        clock_ms = clock_ms + step_ms;
        send_request(rwrm_pkg::OP_TICK, rwrm_pkg::ID_W'($urandom), $urandom, clock_ms);
    endtask

    // Mostly frames with a tick now and then; the clock step is sometimes zero
    // so that snapshots share a stamp, sometimes huge.
    task automatic random_traffic(int count);
        int pick;
        logic [31:0] step_ms;
        logic [31:0] len;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 22) begin
                pick = $urandom_range(99);
                if (pick < 10) step_ms = 0;
                else if (pick < 92) step_ms = $urandom_range(3000, 1);
                else step_ms = $urandom;
                send_tick(step_ms);
            end else begin
                len = ($urandom_range(1) == 0) ? $urandom_range(1500) : $urandom;
                send_frame(($urandom_range(9) == 0) ? 6'd0 : 6'($urandom_range(63)), len);
            end
        end
    endtask

    initial begin
        logic [rwrm_pkg::ID_W-1:0] first_ids [8];
        meter_sb = new();
        meter_sb.mask = '0;
        meter_sb.clear_counters();
        meter_sb.errors = 0;
        sender_idle_pct = 28;
        receiver_idle_pct = 60;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op = rwrm_pkg::OP_FRAME;
        s_track_id = '0;
        s_frame_length = '0;
        s_now_ms = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part: every id maps to a slot except id 0 and ids ranked past
        // the slot count. Eight ticks at one stamp give a zero window time, and
        // the clock then wraps past 2^32 while the peaks climb.
        write_track_mask({rwrm_pkg::MASK_W{1'b1}});
        clock_ms = 32'hFFFF_FF00;
        first_ids = '{6'd0, 6'd1, 6'd8, 6'd9, 6'd63, 6'd2, 6'd5, 6'd40};
        for (int k = 0; k < 8; k++) begin
            send_frame(first_ids[k], (k % 2) ? 32'hFFFF_FFFF : 32'd0);
            send_tick(0);
        end
        send_frame(6'd3, 32'd1500);
        send_tick(500);
        send_frame(6'd7, 32'h8000_0000);
        send_tick(1000);
        send_frame(6'd4, 32'd64);
        send_tick(1);
        send_tick(32'hFFFF_FFFF);
        random_traffic(70);

        sender_idle_pct = 60;
        receiver_idle_pct = 28;
        write_track_mask({$urandom, $urandom});
        clock_ms = $urandom;
        random_traffic(90);

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        write_track_mask('0);
        random_traffic(80);

        // A sparse mask leaves few slots, with ids in and out of it.
        write_track_mask((64'd1 << $urandom_range(63)) | (64'd1 << $urandom_range(63))
                         | (64'd1 << $urandom_range(63)));
        random_traffic(90);

        drain_reports();
        if (meter_sb.errors == 0) begin
            $display("[receive_window_rate_meter_top] OK");
        end else begin
            $display("[receive_window_rate_meter_top] ERROR");
        end
        $finish;
    end

endmodule
